// ----- hw/rtl/euler_rotate_point_transform_core_macros.svh -----
// Assertion macros for the Euler rotation point transform core.
// Used by files that carry concurrent checks; no other dependencies.
`ifndef EULER_ROTATE_POINT_TRANSFORM_CORE_MACROS_SVH
`define EULER_ROTATE_POINT_TRANSFORM_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define ERPT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("erpt check failed");
`define ERPT_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("erpt forbidden condition");
`else
`define ERPT_ASSERT(lbl, clk, rst_n, prop)
`define ERPT_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- hw/rtl/erpt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constant tables for the Euler rotation transform core.
// No dependencies.
package erpt_pkg;

  localparam int CORDIC_W = 35;
  localparam int CORDIC_STEPS = 30;
  localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30 = 35'sh06487ED51;
  localparam logic signed [CORDIC_W-1:0] PI_Q30 = 35'sh0C90FDAA2;
  localparam logic signed [33:0] INV_GAIN_Q30 = 34'sh026DD3B6A;
  localparam logic signed [31:0] ONE_Q16 = 32'sh00010000;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ROTATE = 2'd1,
    ACT_POINT  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    AXIS_Y = 2'd0,
    AXIS_X = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SC_START,
    ST_SC_WAIT,
    ST_ISSUE,
    ST_DRAIN,
    ST_COMMIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic       pt;
    logic [1:0] tag;
  } op_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] rot_coef(
    input axis_e ax, input logic [1:0] k, input logic [1:0] j,
    input logic signed [31:0] c, input logic signed [31:0] s,
    input logic signed [31:0] one);
    logic signed [31:0] v;
    v = '0;
    case (ax)
      AXIS_X: begin
        case ({k, j})
          4'b0000: v = one;
          4'b0101: v = c;
          4'b0110: v = s;
          4'b1001: v = -s;
          4'b1010: v = c;
          4'b1111: v = one;
          default: v = '0;
        endcase
      end
      AXIS_Y: begin
        case ({k, j})
          4'b0000: v = c;
          4'b0010: v = -s;
          4'b0101: v = one;
          4'b1000: v = s;
          4'b1010: v = c;
          4'b1111: v = one;
          default: v = '0;
        endcase
      end
      AXIS_Z: begin
        case ({k, j})
          4'b0000: v = c;
          4'b0001: v = s;
          4'b0100: v = -s;
          4'b0101: v = c;
          4'b1010: v = one;
          4'b1111: v = one;
          default: v = '0;
        endcase
      end
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/erpt_cordic.sv -----
`timescale 1ns / 1ps
// Iterative CORDIC sine/cosine unit, one rotation step per cycle.
// Depends on erpt_pkg.
module erpt_cordic #(
  parameter int ANGLE_WIDTH = 16,
  parameter int COEF_WIDTH  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [ANGLE_WIDTH-1:0] angle_i,
  output logic                          done_o,
  output logic signed [31:0]            cos_o,
  output logic signed [31:0]            sin_o
);
  import erpt_pkg::*;

  localparam int COEF_FRAC = (COEF_WIDTH - 2 < 30) ? COEF_WIDTH - 2 : 30;
  localparam int SH = 30 - COEF_FRAC;
  localparam int ZSH = 33 - ANGLE_WIDTH;
  localparam logic signed [33:0] RND = 34'sd1 <<< SH >>> 1;

  logic                       busy_q, fin_q, done_q, flip_q;
  logic [4:0]                 step_q;
  logic signed [33:0]         x_q, y_q;
  logic signed [CORDIC_W-1:0] z_q, z0, ang;
  logic signed [31:0]         cos_q, sin_q;
  logic signed [33:0]         xf, yf, xr, yr;
  logic signed [CORDIC_W-1:0] atn;

  always_comb begin
    ang = CORDIC_W'(angle_i) <<< ZSH;
    z0  = ang;
    if (ang > HALF_PI_Q30) begin
      z0 = ang - PI_Q30;
    end else if (ang < -HALF_PI_Q30) begin
      z0 = ang + PI_Q30;
    end
    atn = CORDIC_W'(signed'({1'b0, atan_q30(step_q)}));
    xf  = flip_q ? -x_q : x_q;
    yf  = flip_q ? -y_q : y_q;
    xr  = (xf + RND) >>> SH;
    yr  = (yf + RND) >>> SH;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 5'd1;
        if (step_q == 5'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      x_q    <= INV_GAIN_Q30;
      y_q    <= '0;
      z_q    <= z0;
      flip_q <= (ang > HALF_PI_Q30) || (ang < -HALF_PI_Q30);
    end else if (busy_q) begin
      if (!z_q[CORDIC_W-1]) begin
        x_q <= x_q - (y_q >>> step_q);
        y_q <= y_q + (x_q >>> step_q);
        z_q <= z_q - atn;
      end else begin
        x_q <= x_q + (y_q >>> step_q);
        y_q <= y_q - (x_q >>> step_q);
        z_q <= z_q + atn;
      end
    end
    if (fin_q) begin
      cos_q <= 32'(xr);
      sin_q <= 32'(yr);
    end
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

endmodule

// ----- hw/rtl/erpt_lane.sv -----
`timescale 1ns / 1ps
// One multiply lane: registers the full product of two signed words.
// Depends on erpt_pkg.
module erpt_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  erpt_pkg::op_t       op_i,
  input  logic signed [31:0]  a_i,
  input  logic signed [31:0]  b_i,
  output erpt_pkg::op_t       op_o,
  output logic signed [63:0]  prod_o
);
  import erpt_pkg::*;

  op_t                op_q;
  logic signed [63:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= '0;
    end else begin
      op_q <= op_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.valid) begin
      prod_q <= a_i * b_i;
    end
  end

  assign op_o   = op_q;
  assign prod_o = prod_q;

endmodule

// ----- hw/rtl/erpt_merge.sv -----
`timescale 1ns / 1ps
// Merge stage: sums the four lane products, rounds half up and saturates.
// Depends on erpt_pkg.
module erpt_merge #(
  parameter int COEF_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  erpt_pkg::op_t      op_i,
  input  logic signed [63:0] prod_i [4],
  output erpt_pkg::op_t      op_o,
  output logic signed [31:0] res_o
);
  import erpt_pkg::*;

  localparam int COEF_FRAC = (COEF_WIDTH - 2 < 30) ? COEF_WIDTH - 2 : 30;
  localparam logic signed [65:0] HALF_PT = 66'sd1 <<< 15;
  localparam logic signed [65:0] HALF_CF = 66'sd1 <<< (COEF_FRAC - 1);
  localparam logic signed [65:0] MAX32 = 66'sh07FFFFFFF;
  localparam logic signed [65:0] MIN32 = -66'sh080000000;

  op_t                op1_q, op2_q;
  logic signed [64:0] s01_q, s23_q;
  logic signed [65:0] tot, shv;
  logic signed [31:0] res_q, sat;

  always_comb begin
    tot = 66'(s01_q) + 66'(s23_q) + (op1_q.pt ? HALF_PT : HALF_CF);
    shv = op1_q.pt ? (tot >>> 16) : (tot >>> COEF_FRAC);
    if (shv > MAX32) begin
      sat = 32'sh7FFFFFFF;
    end else if (shv < MIN32) begin
      sat = 32'sh80000000;
    end else begin
      sat = 32'(shv);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op1_q <= '0;
      op2_q <= '0;
    end else begin
      op1_q <= op_i;
      op2_q <= op1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.valid) begin
      s01_q <= 65'(prod_i[0]) + 65'(prod_i[1]);
      s23_q <= 65'(prod_i[2]) + 65'(prod_i[3]);
    end
    if (op1_q.valid) begin
      res_q <= sat;
    end
  end

  assign op_o  = op2_q;
  assign res_o = res_q;

endmodule

// ----- hw/rtl/euler_rotate_point_transform_core.sv -----
`timescale 1ns / 1ps
// Euler rotation and affine point transform core (top level).
// Depends on erpt_pkg, erpt_cordic, erpt_lane, erpt_merge and the macros header.
// Input channel (in_valid_i / in_stall_o) carries one word per item: action 0
// writes one entry of the 4x4 Q16.16 matrix, action 1 replaces the matrix by
// M*Ry*Rx*Rz from three Q3.13 angles, action 2 transforms point (x,y,z,1).
// Action 3 does nothing. Only point words produce an output word on
// out_valid_o / out_stall_i with saturated out_x/out_y/out_z.
// A point is accepted, its three column dot products are issued to four multiply
// lanes and pass through the lane product, merge sum and merge result registers,
// and the result then goes to the output register that drives out_valid_o.
// A rotation runs, per axis, the iterative CORDIC (start, 30 steps, round,
// done) and then four rows through the lanes and merge stage.
// One word is worked on at a time; in_stall_o is high while busy.
// A finished point result waits in the output register while out_stall_i
// is high; the next input word is taken meanwhile and the core holds in its
// output step only if a second result is ready before the first is taken.
// Reset sets the matrix to identity and empties all stages.
`include "euler_rotate_point_transform_core_macros.svh"
module euler_rotate_point_transform_core #(
  parameter int ANGLE_WIDTH = 16,
  parameter int COEF_WIDTH  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    action_i,
  input  logic [1:0]                    entry_row_i,
  input  logic [1:0]                    entry_col_i,
  input  logic signed [31:0]            entry_value_i,
  input  logic signed [ANGLE_WIDTH-1:0] angle_x_i,
  input  logic signed [ANGLE_WIDTH-1:0] angle_y_i,
  input  logic signed [ANGLE_WIDTH-1:0] angle_z_i,
  input  logic signed [31:0]            point_x_i,
  input  logic signed [31:0]            point_y_i,
  input  logic signed [31:0]            point_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            out_x_o,
  output logic signed [31:0]            out_y_o,
  output logic signed [31:0]            out_z_o
);
  import erpt_pkg::*;

  localparam int COEF_FRAC = (COEF_WIDTH - 2 < 30) ? COEF_WIDTH - 2 : 30;
  localparam logic signed [31:0] COEF_ONE = 32'(64'sd1 <<< COEF_FRAC);

  state_e                       state_q, state_d;
  axis_e                        axis_q, axis_d;
  logic [1:0]                   row_q, row_d, col_q, col_d;
  logic                         pt_q, out_valid_q;
  logic signed [31:0]           m_q [16];
  logic signed [31:0]           res_q [4];
  logic signed [31:0]           pnt_q [3];
  logic signed [ANGLE_WIDTH-1:0] ang_q [3];
  logic signed [ANGLE_WIDTH-1:0] ang_sel;
  logic signed [31:0]           out_x_q, out_y_q, out_z_q;
  logic                         accept, ld_we, commit_we, out_load, cs_start, cs_done;
  logic signed [31:0]           cs_cos, cs_sin;
  op_t                          op, mrg_op, lane_op;
  logic signed [31:0]           lane_a [4];
  logic signed [31:0]           lane_b [4];
  logic signed [63:0]           lane_p [4];
  logic signed [31:0]           mrg_res;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    case (axis_q)
      AXIS_X:  ang_sel = ang_q[0];
      AXIS_Y:  ang_sel = ang_q[1];
      AXIS_Z:  ang_sel = ang_q[2];
      default: ang_sel = ang_q[1];
    endcase
  end

  erpt_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cs_start),
    .angle_i (ang_sel),
    .done_o  (cs_done),
    .cos_o   (cs_cos),
    .sin_o   (cs_sin)
  );

  for (genvar k = 0; k < 4; k++) begin : g_lane
    always_comb begin
      if (pt_q) begin
        lane_a[k] = (k < 3) ? pnt_q[(k < 3) ? k : 0] : ONE_Q16;
        lane_b[k] = m_q[{2'(k), col_q}];
      end else begin
        lane_a[k] = m_q[{row_q, 2'(k)}];
        lane_b[k] = rot_coef(axis_q, 2'(k), col_q, cs_cos, cs_sin, COEF_ONE);
      end
    end
    if (k == 0) begin : g_first
      erpt_lane u_lane (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .op_i   (op),
        .a_i    (lane_a[k]),
        .b_i    (lane_b[k]),
        .op_o   (lane_op),
        .prod_o (lane_p[k])
      );
    end else begin : g_other
      erpt_lane u_lane (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .op_i   (op),
        .a_i    (lane_a[k]),
        .b_i    (lane_b[k]),
        .op_o   (),
        .prod_o (lane_p[k])
      );
    end
  end

  erpt_merge #(.COEF_WIDTH(COEF_WIDTH)) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (lane_op),
    .prod_i (lane_p),
    .op_o   (mrg_op),
    .res_o  (mrg_res)
  );

  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    row_d     = row_q;
    col_d     = col_q;
    op        = '0;
    cs_start  = 1'b0;
    ld_we     = 1'b0;
    commit_we = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (action_e'(action_i))
            ACT_LOAD:   ld_we = 1'b1;
            ACT_ROTATE: begin
              axis_d  = AXIS_Y;
              state_d = ST_SC_START;
            end
            ACT_POINT: begin
              col_d   = '0;
              state_d = ST_ISSUE;
            end
            default: ;
          endcase
        end
      end
      ST_SC_START: begin
        cs_start = 1'b1;
        state_d  = ST_SC_WAIT;
      end
      ST_SC_WAIT: begin
        if (cs_done) begin
          row_d   = '0;
          col_d   = '0;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        op.valid = 1'b1;
        op.pt    = pt_q;
        op.tag   = col_q;
        op.last  = pt_q ? (col_q == 2'd2) : (col_q == 2'd3);
        col_d    = col_q + 2'd1;
        if (op.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mrg_op.valid && mrg_op.last) begin
          state_d = pt_q ? ST_OUT : ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        commit_we = 1'b1;
        if (row_q == 2'd3) begin
          case (axis_q)
            AXIS_Y: begin
              axis_d  = AXIS_X;
              state_d = ST_SC_START;
            end
            AXIS_X: begin
              axis_d  = AXIS_Z;
              state_d = ST_SC_START;
            end
            default: state_d = ST_IDLE;
          endcase
        end else begin
          row_d   = row_q + 2'd1;
          col_d   = '0;
          state_d = ST_ISSUE;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= AXIS_Y;
      row_q       <= '0;
      col_q       <= '0;
      pt_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      row_q   <= row_d;
      col_q   <= col_d;
      if (accept) begin
        pt_q <= (action_e'(action_i) == ACT_POINT);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        m_q[i] <= (i % 5 == 0) ? ONE_Q16 : '0;
      end
    end else if (ld_we) begin
      m_q[{entry_row_i, entry_col_i}] <= entry_value_i;
    end else if (commit_we) begin
      for (int c = 0; c < 4; c++) begin
        m_q[{row_q, 2'(c)}] <= res_q[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ang_q[0] <= angle_x_i;
      ang_q[1] <= angle_y_i;
      ang_q[2] <= angle_z_i;
      pnt_q[0] <= point_x_i;
      pnt_q[1] <= point_y_i;
      pnt_q[2] <= point_z_i;
    end
    if (mrg_op.valid) begin
      res_q[mrg_op.tag] <= mrg_res;
    end
    if (out_load) begin
      out_x_q <= res_q[0];
      out_y_q <= res_q[1];
      out_z_q <= res_q[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;

  `ERPT_ASSERT(a_mrg_busy, clk_i, rst_ni, mrg_op.valid |-> (state_q == ST_ISSUE || state_q == ST_DRAIN))
  `ERPT_ASSERT(a_out_from_out, clk_i, rst_ni, $rose(out_valid_o) |-> ($past(state_q) == ST_OUT))
  `ERPT_ASSERT(a_cs_done_wait, clk_i, rst_ni, cs_done |-> (state_q == ST_SC_WAIT))
  `ERPT_ASSERT_NEVER(a_pt_three_cols, clk_i, rst_ni, state_q == ST_ISSUE && pt_q && col_q == 2'd3)

endmodule
